// ===== rtl/bc1_pkg.sv =====
// ----------------------------------------------------------------------------
// bc1_pkg
// shared types and helpers for the bc1 block encoder pipeline
// ----------------------------------------------------------------------------
package bc1_pkg;

    localparam int unsigned NumPix   = 16;
    localparam int unsigned NumPal   = 4;
    localparam int unsigned ChanW    = 8;
    localparam int unsigned DistW    = 18;
    localparam logic [7:0]  Mask5    = 8'hF8;
    localparam logic [7:0]  Mask6    = 8'hFC;
    localparam int unsigned RedShift = 11;
    // reciprocal of three, exact for sums up to 765
    localparam logic [9:0]  Recip3   = 10'd683;
    localparam int unsigned Recip3Sh = 11;

    typedef logic [2:0][ChanW-1:0]       t_rgb;
    typedef logic [NumPix-1:0][23:0]     t_block;
    typedef logic [NumPal-1:0][DistW-1:0] t_dist4;

    function automatic logic [7:0] expand5(input logic [7:0] v);
        return (v & Mask5) | {5'd0, v[7:5]};
    endfunction

    function automatic logic [7:0] expand6(input logic [7:0] v);
        return (v & Mask6) | {6'd0, v[7:6]};
    endfunction

    function automatic logic [15:0] pack565(input t_rgb c);
        logic [15:0] r;
        r = ({11'd0, c[0][7:3]} << RedShift) | {5'd0, c[1][7:2], 5'd0} | {11'd0, c[2][7:3]};
        return r;
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = x * Recip3;
        return 8'(p >> Recip3Sh);
    endfunction

endpackage

// ===== rtl/dxt1_block_encoder.sv =====
// ----------------------------------------------------------------------------
// dxt1_block_encoder
// five-stage pipelined bc1 (dxt1) colour block encoder
// ----------------------------------------------------------------------------
// One 4x4 rgb block is accepted per beat and one bc1 code (two rgb565
// endpoints plus sixteen 2-bit indices) leaves per beat; the pipeline takes
// a new block every cycle while o_stall is low, and each block passes the
// five register stages: min/max tree, inset and 565 endpoints, thirds of the
// palette, distance squares, nearest-entry selection. Each stage holds its
// own valid bit and loads whenever it is empty or its successor moves, so
// bubbles collapse and a stall at the output backs up without loss. Endpoints
// are never swapped, so a flat block gives equal endpoints and all-zero
// indices; ties in distance keep the lower index.
module dxt1_block_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [47:0] i_pixels_01,
    input  logic [47:0] i_pixels_23,
    input  logic [47:0] i_pixels_45,
    input  logic [47:0] i_pixels_67,
    input  logic [47:0] i_pixels_89,
    input  logic [47:0] i_pixels_ab,
    input  logic [47:0] i_pixels_cd,
    input  logic [47:0] i_pixels_ef,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_endpoint_high,
    output logic [15:0] o_endpoint_low,
    output logic [31:0] o_index_bits
);
    import bc1_pkg::*;

    // stage valid bits and load enables
    logic [5:1] r_v;
    logic [5:1] n_v;
    logic [5:1] ld;

    t_block in_block;

    // stage 1: min/max
    t_block r1_blk;
    t_rgb   r1_lo, r1_hi, mm_lo, mm_hi;
    // stage 2: endpoints
    t_block      r2_blk;
    logic [15:0] r2_eh, r2_el, ep_h, ep_l;
    t_rgb        r2_p0, r2_p1, e_p0, e_p1;
    // stage 3: full palette
    t_block      r3_blk;
    logic [15:0] r3_eh, r3_el;
    t_rgb        r3_pal [4];
    // stage 4: distances
    logic [15:0] r4_eh, r4_el;
    t_dist4      r4_dist  [NumPix];
    t_dist4      pix_dist [NumPix];
    // stage 5: output
    logic [15:0] r5_eh, r5_el;
    logic [31:0] r5_idx, n_idx;

    assign in_block = {i_pixels_ef, i_pixels_cd, i_pixels_ab, i_pixels_89,
                       i_pixels_67, i_pixels_45, i_pixels_23, i_pixels_01};

    // ready ripples back from the output register
    always_comb begin
        ld[5] = !r_v[5] || !i_stall;
        for (int k = 4; k >= 1; k--) begin
            ld[k] = !r_v[k] || ld[k+1];
        end
        n_v[1] = ld[1] ? i_valid : r_v[1];
        for (int k = 2; k <= 5; k++) begin
            n_v[k] = ld[k] ? r_v[k-1] : r_v[k];
        end
    end

    assign o_stall = !ld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    bc1_minmax u_minmax (
        .i_block (in_block),
        .o_lo    (mm_lo),
        .o_hi    (mm_hi)
    );

    bc1_endpoint u_endpoint (
        .i_lo      (r1_lo),
        .i_hi      (r1_hi),
        .o_ep_high (ep_h),
        .o_ep_low  (ep_l),
        .o_pal0    (e_p0),
        .o_pal1    (e_p1)
    );

    for (genvar p = 0; p < NumPix; p++) begin : g_dist
        bc1_dist u_dist (
            .i_pix  (r3_blk[p]),
            .i_pal  (r3_pal),
            .o_dist (pix_dist[p])
        );
    end

    // nearest entry, strict compare keeps the first minimum
    always_comb begin
        logic [DistW-1:0] best;
        logic [1:0]       sel;
        n_idx = '0;
        for (int p = 0; p < NumPix; p++) begin
            best = r4_dist[p][0];
            sel  = 2'd0;
            for (int j = 1; j < NumPal; j++) begin
                if (r4_dist[p][j] < best) begin
                    best = r4_dist[p][j];
                    sel  = 2'(j);
                end
            end
            n_idx[2*p +: 2] = sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_blk <= in_block;
            r1_lo  <= mm_lo;
            r1_hi  <= mm_hi;
        end
        if (ld[2]) begin
            r2_blk <= r1_blk;
            r2_eh  <= ep_h;
            r2_el  <= ep_l;
            r2_p0  <= e_p0;
            r2_p1  <= e_p1;
        end
        if (ld[3]) begin
            r3_blk    <= r2_blk;
            r3_eh     <= r2_eh;
            r3_el     <= r2_el;
            r3_pal[0] <= r2_p0;
            r3_pal[1] <= r2_p1;
            for (int c = 0; c < 3; c++) begin
                r3_pal[2][c] <= div3({1'b0, r2_p0[c], 1'b0} + {2'd0, r2_p1[c]});
                r3_pal[3][c] <= div3({2'd0, r2_p0[c]} + {1'b0, r2_p1[c], 1'b0});
            end
        end
        if (ld[4]) begin
            r4_eh   <= r3_eh;
            r4_el   <= r3_el;
            r4_dist <= pix_dist;
        end
        if (ld[5]) begin
            r5_eh  <= r4_eh;
            r5_el  <= r4_el;
            r5_idx <= n_idx;
        end
    end

    assign o_valid         = r_v[5];
    assign o_endpoint_high = r5_eh;
    assign o_endpoint_low  = r5_el;
    assign o_index_bits    = r5_idx;

    // inset never crosses the channels, so high red never falls below low red
    a_red_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_endpoint_high[15:11] >= o_endpoint_low[15:11]))
        else $error("endpoint red order broken");

    // equal endpoints give a flat palette, every pixel picks the first entry
    a_flat_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_endpoint_high == o_endpoint_low)) |-> (o_index_bits == '0))
        else $error("flat palette gave nonzero index");

    // a stalled result stays put and is not overwritten by a younger block
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r5_idx) && $stable(r5_eh)))
        else $error("stalled result lost");

    // input is taken only when stage one has room
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !ld[2]) |-> o_stall)
        else $error("stage one overrun");

endmodule

// ===== rtl/bc1_minmax.sv =====
// ----------------------------------------------------------------------------
// bc1_minmax
// per-channel minimum and maximum over the sixteen pixels, four-level tree
// ----------------------------------------------------------------------------
module bc1_minmax (
    input  bc1_pkg::t_block i_block,
    output bc1_pkg::t_rgb   o_lo,
    output bc1_pkg::t_rgb   o_hi
);
    import bc1_pkg::*;

    t_rgb lo_l [5][NumPix];
    t_rgb hi_l [5][NumPix];

    always_comb begin
        for (int p = 0; p < NumPix; p++) begin
            lo_l[0][p] = i_block[p];
            hi_l[0][p] = i_block[p];
        end
        for (int l = 1; l < 5; l++) begin
            for (int p = 0; p < NumPix; p++) begin
                lo_l[l][p] = '0;
                hi_l[l][p] = '0;
            end
            for (int p = 0; p < (NumPix >> l); p++) begin
                for (int c = 0; c < 3; c++) begin
                    lo_l[l][p][c] = (lo_l[l-1][2*p][c] < lo_l[l-1][2*p+1][c])
                                    ? lo_l[l-1][2*p][c] : lo_l[l-1][2*p+1][c];
                    hi_l[l][p][c] = (hi_l[l-1][2*p][c] > hi_l[l-1][2*p+1][c])
                                    ? hi_l[l-1][2*p][c] : hi_l[l-1][2*p+1][c];
                end
            end
        end
    end

    assign o_lo = lo_l[4][0];
    assign o_hi = hi_l[4][0];

endmodule

// ===== rtl/bc1_endpoint.sv =====
// ----------------------------------------------------------------------------
// bc1_endpoint
// inset of the extremes, 565 packing and expansion back to eight bits
// ----------------------------------------------------------------------------
module bc1_endpoint (
    input  bc1_pkg::t_rgb   i_lo,
    input  bc1_pkg::t_rgb   i_hi,
    output logic [15:0]     o_ep_high,
    output logic [15:0]     o_ep_low,
    output bc1_pkg::t_rgb   o_pal0,
    output bc1_pkg::t_rgb   o_pal1
);
    import bc1_pkg::*;

    t_rgb       lo_in;
    t_rgb       hi_in;
    logic [7:0] ins;
    logic [8:0] sum;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ins = (i_hi[c] - i_lo[c]) >> 4;
            sum = {1'b0, i_lo[c]} + {1'b0, ins};
            lo_in[c] = sum[8] ? 8'hFF : sum[7:0];
            hi_in[c] = (i_hi[c] < ins) ? 8'd0 : i_hi[c] - ins;
        end
        o_pal0 = {expand5(hi_in[2]), expand6(hi_in[1]), expand5(hi_in[0])};
        o_pal1 = {expand5(lo_in[2]), expand6(lo_in[1]), expand5(lo_in[0])};
    end

    assign o_ep_high = pack565(hi_in);
    assign o_ep_low  = pack565(lo_in);

endmodule

// ===== rtl/bc1_dist.sv =====
// ----------------------------------------------------------------------------
// bc1_dist
// squared rgb distance of one pixel to each of the four palette entries
// ----------------------------------------------------------------------------
module bc1_dist (
    input  logic [23:0]     i_pix,
    input  bc1_pkg::t_rgb   i_pal [4],
    output bc1_pkg::t_dist4 o_dist
);
    import bc1_pkg::*;

    logic signed [8:0]  diff;
    logic        [16:0] sq;

    always_comb begin
        for (int j = 0; j < NumPal; j++) begin
            o_dist[j] = '0;
            for (int c = 0; c < 3; c++) begin
                diff = $signed({1'b0, i_pix[8*c +: 8]}) - $signed({1'b0, i_pal[j][c]});
                sq   = 17'(diff * diff);
                o_dist[j] = o_dist[j] + {1'b0, sq};
            end
        end
    end

endmodule
